// ----- design/lwtf_pkg.sv -----
// Shared types, codes and constants for the low-rate WPAN transmit framer.
`timescale 1ns / 1ps

package lwtf_pkg;

  localparam int MAX_FRAME_LEN = 127;
  localparam int IN_DATA_W = 96;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int HDR_LEN_LONG = 19;
  localparam int HDR_LEN_SHORT = 11;
  localparam int HDR_LEN_SHORT_COMP = 9;
  localparam int HDR_IDX_W = $clog2(HDR_LEN_LONG + 1);
  localparam int FCS_LEN = 2;
  localparam int SIZE_W = 9;

  localparam logic [7:0] FC_ACK_REQ = 8'h20;
  localparam logic [7:0] FC_PAN_COMP = 8'h40;
  localparam logic [7:0] FC_HIGH_LONG = 8'hcc;
  localparam logic [7:0] FC_HIGH_SHORT = 8'h88;
  localparam logic [7:0] ACK_FRAME_BYTE = 8'h02;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BUSY      = 3'd3,
    ST_SYNC_ERR  = 3'd4,
    ST_UNDERFLOW = 3'd5,
    ST_NO_ACK    = 3'd6
  } status_t;

  typedef enum logic {
    CMD_BUILD   = 1'b0,
    CMD_OUTCOME = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    KIND_BEACON      = 2'd0,
    KIND_DATA        = 2'd1,
    KIND_ACK         = 2'd2,
    KIND_UNSUPPORTED = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OWN_PAN   = 2'd0,
    CFG_OWN_SHORT = 2'd1,
    CFG_OWN_LONG  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] own_pan_id;
    logic [15:0] own_short_addr;
    logic [63:0] own_ext_addr;
  } cfg_t;

  typedef struct packed {
    logic                 status_only;
    status_t              status;
    logic [7:0]           len_byte;
    logic [7:0]           fc_low;
    logic [7:0]           seq;
    logic                 ext_addr;
    logic                 pan_comp;
    logic [HDR_IDX_W-1:0] last_idx;
    logic [63:0]          dest;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- design/lwtf_front.sv -----
// Front end: accepts request beats, keeps sequence state and classifies each into a job.
`timescale 1ns / 1ps

module lwtf_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lwtf_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  lwtf_pkg::cfg_t                  cfg,
  input  logic                            q_ready,
  output logic                            push,
  output lwtf_pkg::job_t                  job
);

  logic [7:0] next_sequence;
  logic       awaiting_ack;

  lwtf_pkg::kind_t                    kind;
  logic                               ext_addr;
  logic                               ack_request;
  logic [63:0]                        dest_addr;
  logic [7:0]                         body_len;
  logic                               channel_clear;
  logic                               sync_timed_out;
  logic                               tx_underflow;
  logic                               ack_arrived;
  logic [7:0]                         ack_first_byte;
  logic [7:0]                         ack_seq;
  logic                               pan_comp;
  logic [lwtf_pkg::HDR_IDX_W-1:0]     hdr_len;
  logic [lwtf_pkg::SIZE_W-1:0]        frame_size;
  logic                               take_seq;

  assign s_tready = q_ready;
  assign push = s_tvalid && q_ready;

  always_comb begin
    kind = lwtf_pkg::kind_t'(s_tdata[1:0]);
    ext_addr = s_tdata[2];
    ack_request = s_tdata[3];
    dest_addr = s_tdata[67:4];
    body_len = s_tdata[75:68];
    channel_clear = s_tdata[76];
    sync_timed_out = s_tdata[77];
    tx_underflow = s_tdata[78];
    ack_arrived = s_tdata[79];
    ack_first_byte = s_tdata[87:80];
    ack_seq = s_tdata[95:88];

    pan_comp = !ext_addr && (dest_addr[15:0] == cfg.own_pan_id);
    if (ext_addr) begin
      hdr_len = lwtf_pkg::HDR_IDX_W'(lwtf_pkg::HDR_LEN_LONG);
    end else if (pan_comp) begin
      hdr_len = lwtf_pkg::HDR_IDX_W'(lwtf_pkg::HDR_LEN_SHORT_COMP);
    end else begin
      hdr_len = lwtf_pkg::HDR_IDX_W'(lwtf_pkg::HDR_LEN_SHORT);
    end
    frame_size = lwtf_pkg::SIZE_W'(hdr_len) + lwtf_pkg::SIZE_W'(body_len)
                 + lwtf_pkg::SIZE_W'(lwtf_pkg::FCS_LEN);

    job.status_only = 1'b1;
    job.status = lwtf_pkg::ST_OK;
    job.len_byte = frame_size[7:0];
    job.fc_low = {6'b0, kind} | (ack_request ? lwtf_pkg::FC_ACK_REQ : 8'h00)
                 | (pan_comp ? lwtf_pkg::FC_PAN_COMP : 8'h00);
    job.seq = next_sequence;
    job.ext_addr = ext_addr;
    job.pan_comp = pan_comp;
    job.last_idx = hdr_len;
    job.dest = dest_addr;
    take_seq = 1'b0;

    if (lwtf_pkg::command_t'(s_tuser) == lwtf_pkg::CMD_OUTCOME) begin
      priority if (!channel_clear) begin
        job.status = lwtf_pkg::ST_BUSY;
      end else if (sync_timed_out) begin
        job.status = lwtf_pkg::ST_SYNC_ERR;
      end else if (tx_underflow) begin
        job.status = lwtf_pkg::ST_UNDERFLOW;
      end else if (!awaiting_ack) begin
        job.status = lwtf_pkg::ST_OK;
      end else if (ack_arrived && (ack_first_byte == lwtf_pkg::ACK_FRAME_BYTE)
                   && (ack_seq == next_sequence - 8'd1)) begin
        job.status = lwtf_pkg::ST_OK;
      end else begin
        job.status = lwtf_pkg::ST_NO_ACK;
      end
    end else if (kind == lwtf_pkg::KIND_UNSUPPORTED) begin
      job.status = lwtf_pkg::ST_INVALID;
    end else begin
      take_seq = 1'b1;
      if (frame_size > lwtf_pkg::SIZE_W'(lwtf_pkg::MAX_FRAME_LEN)) begin
        job.status = lwtf_pkg::ST_TOO_LONG;
      end else begin
        job.status_only = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_sequence <= 8'd0;
      awaiting_ack <= 1'b0;
    end else if (push && take_seq) begin
      next_sequence <= next_sequence + 8'd1;
      awaiting_ack <= ack_request;
    end
  end

endmodule

// ----- design/lwtf_queue.sv -----
// Two-entry show-ahead job queue between the front end and the byte serializer.
`timescale 1ns / 1ps

module lwtf_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  lwtf_pkg::job_t           push_job,
  output logic                     ready,
  input  logic                     pop,
  output logic                     head_valid,
  output lwtf_pkg::job_t           head_job,
  output lwtf_pkg::queue_status_t  status
);

  lwtf_pkg::job_t                   mem [lwtf_pkg::QUEUE_DEPTH];
  logic [lwtf_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [lwtf_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [lwtf_pkg::QUEUE_CNT_W-1:0] count;
  logic                             do_push;
  logic                             do_pop;

  assign status.full = (count == lwtf_pkg::QUEUE_CNT_W'(lwtf_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign ready = !status.full;
  assign head_valid = !status.empty;
  assign head_job = mem[rd_ptr];
  assign do_push = push && ready;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == lwtf_pkg::QUEUE_PTR_W'(lwtf_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == lwtf_pkg::QUEUE_PTR_W'(lwtf_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/lwtf_back.sv -----
// Back end: serializes each queued job into length and header byte beats, or a status beat.
`timescale 1ns / 1ps

module lwtf_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             head_valid,
  input  lwtf_pkg::job_t                   head_job,
  input  lwtf_pkg::cfg_t                   cfg,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lwtf_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tuser,
  output logic                             m_tlast
);

  logic [lwtf_pkg::HDR_IDX_W-1:0] cnt;
  logic [lwtf_pkg::HDR_IDX_W-1:0] hdr_idx;
  logic [7:0]                     hdr [lwtf_pkg::HDR_LEN_LONG];
  logic                           load;
  logic [7:0]                     beat_byte;
  logic                           beat_valid;
  lwtf_pkg::status_t              beat_status;
  logic                           beat_last;
  logic [7:0]                     frame_byte;
  lwtf_pkg::status_t              status;

  assign load = head_valid && (!m_tvalid || m_tready);
  assign hdr_idx = cnt - 1'b1;

  always_comb begin
    for (int i = 0; i < lwtf_pkg::HDR_LEN_LONG; i++) begin
      hdr[i] = 8'h00;
    end
    hdr[0] = head_job.fc_low;
    hdr[2] = head_job.seq;
    if (head_job.ext_addr) begin
      hdr[1] = lwtf_pkg::FC_HIGH_LONG;
      for (int i = 0; i < 8; i++) begin
        hdr[3 + i] = head_job.dest[8*i +: 8];
        hdr[11 + i] = cfg.own_ext_addr[8*i +: 8];
      end
    end else begin
      hdr[1] = lwtf_pkg::FC_HIGH_SHORT;
      hdr[3] = head_job.dest[7:0];
      hdr[4] = head_job.dest[15:8];
      hdr[5] = head_job.dest[23:16];
      hdr[6] = head_job.dest[31:24];
      if (head_job.pan_comp) begin
        hdr[7] = cfg.own_short_addr[7:0];
        hdr[8] = cfg.own_short_addr[15:8];
      end else begin
        hdr[7] = cfg.own_pan_id[7:0];
        hdr[8] = cfg.own_pan_id[15:8];
        hdr[9] = cfg.own_short_addr[7:0];
        hdr[10] = cfg.own_short_addr[15:8];
      end
    end
  end

  always_comb begin
    beat_byte = 8'h00;
    beat_valid = 1'b0;
    beat_status = head_job.status;
    beat_last = 1'b1;
    if (!head_job.status_only) begin
      beat_valid = 1'b1;
      beat_status = lwtf_pkg::ST_OK;
      if (cnt == '0) begin
        beat_byte = head_job.len_byte;
        beat_last = 1'b0;
      end else begin
        beat_byte = hdr[hdr_idx];
        beat_last = (cnt == head_job.last_idx);
      end
    end
    pop = load && beat_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cnt <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load) begin
        cnt <= beat_last ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= beat_byte;
      status <= beat_status;
      m_tuser <= beat_valid;
      m_tlast <= beat_last;
    end
  end

  assign m_tdata = {5'b0, status, frame_byte};

endmodule

// ----- design/lowrate_wpan_tx_framer.sv -----
// Top level of the low-rate WPAN transmit framer: config registers, front, queue and back.
//
// Channel   Direction  Beat contents
// s_*       in         one build or outcome request (tuser = command)
// m_*       out        one length, header or status byte (tuser = byte_valid)
// cfg_*     in         one write of own_pan_id, own_short_addr or own_ext_addr
//
// A build request yields header length plus one beats (10, 12 or 20), one per cycle unless
// stalled; a rejected build or an outcome request yields a single status beat. The byte
// serializer in the back end sets the rate; a two-entry job queue lets the front end
// take new requests while earlier ones are still being emitted. Reset is synchronous
// and clears the sequence counter, the ack flag, the queue and the config registers.
// Output stalls hold the output register and fill the queue before s_tready drops.
`timescale 1ns / 1ps

module lowrate_wpan_tx_framer (
  input  logic                              clk,
  input  logic                              rst,
  // frame_kind[1:0], ext_addr_mode, ack_request, dest_addr[63:0], body_len[7:0],
  // channel_clear, sync_timed_out, tx_underflow, ack_arrived, ack_first_byte[7:0],
  // ack_seq[7:0]
  input  logic [lwtf_pkg::IN_DATA_W-1:0]    s_tdata,
  // command
  input  logic                              s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // frame_byte[7:0], status[2:0], zero fill
  output logic [lwtf_pkg::OUT_DATA_W-1:0]   m_tdata,
  // byte_valid
  output logic                              m_tuser,
  output logic                              m_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lwtf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [63:0]                       cfg_data
);

  lwtf_pkg::cfg_t          cfg;
  lwtf_pkg::job_t          push_job;
  lwtf_pkg::job_t          head_job;
  lwtf_pkg::queue_status_t q_stat;
  logic                    q_ready;
  logic                    push;
  logic                    pop;
  logic                    head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (lwtf_pkg::cfg_index_t'(cfg_index))
        lwtf_pkg::CFG_OWN_PAN:   cfg.own_pan_id <= cfg_data[15:0];
        lwtf_pkg::CFG_OWN_SHORT: cfg.own_short_addr <= cfg_data[15:0];
        lwtf_pkg::CFG_OWN_LONG:  cfg.own_ext_addr <= cfg_data;
        default: ;
      endcase
    end
  end

  lwtf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_ready  (q_ready),
    .push     (push),
    .job      (push_job)
  );

  lwtf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .status     (q_stat)
  );

  lwtf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .cfg        (cfg),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  a_status_beat_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[7:0] == 8'h00))
    else $error("Status beat carries a byte or is not marked last.");

  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("Job queue reports full and empty at once.");

  a_header_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid && m_tuser)
    else $error("Header byte stream broke off before its last beat.");

endmodule
